[rtl/rme_pkg.sv]
package rme_pkg;

    localparam int KB = 27;
    // One pipeline stage per quotient bit of the base reduction, then one
    // stage per multiplier bit for each square and each multiply.
    localparam int RED_STAGES = KB;
    localparam int MM_STAGES  = 2 * KB * KB;
    localparam int N_STAGES   = RED_STAGES + MM_STAGES;
    localparam int ADDR_W     = 4;

    typedef logic [KB-1:0] t_key;

    typedef enum logic [1:0] {
        REG_MODULUS = 2'd0,
        REG_ENC_EXP = 2'd1,
        REG_DEC_EXP = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic func;
        t_key base;
        t_key pw;
        t_key mm;
    } t_lane;

    // (a + b) mod m for a, b below m.
    function automatic t_key add_mod(input t_key a, input t_key b, input t_key m);
        t_key room;
        room = m - b;
        if (a >= room) begin
            return a - room;
        end
        return a + b;
    endfunction

endpackage

[rtl/rsa_modular_exponentiation.sv]
// Textbook RSA modular exponentiation, fully pipelined.
// Input channel: i_valid, i_func, i_value, with o_stall back to the sender.
// A transaction with i_func low raises i_value to the encryption exponent,
// with i_func high to the decryption exponent, both modulo the modulus.
// Output channel: o_valid, o_result, with i_stall from the receiver.
// The modulus and both exponents are written through the APB-style port
// at byte addresses 0, 4 and 8; they may change only while the block holds
// no transaction in flight.
// 27 stages reduce the base (one quotient bit each), and then each of the
// 27 exponent bits takes one modular squaring and one modular multiply of
// 27 stages each, one multiplier bit per stage.
// Throughput is one transaction per cycle while the receiver holds no result.
// When the receiver stalls a valid result, the whole pipeline holds and
// o_stall is raised; nothing is lost or repeated. Empty stages do not
// block, so a stall with no result waiting leaves the input open.
// Reset clears all valid bits and loads modulus 2 and both exponents 1.
// A modulus below two yields a result of zero.
module rsa_modular_exponentiation
    import rme_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic [KB-1:0]     i_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KB-1:0]     o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_key r_modulus;
    t_key r_enc_exp;
    t_key r_dec_exp;

    logic  en;
    logic  stage_valid [N_STAGES+1];
    t_lane stage_lane  [N_STAGES+1];

    // Configuration registers.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= t_key'(2);
            r_enc_exp <= t_key'(1);
            r_dec_exp <= t_key'(1);
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_MODULUS: r_modulus <= pwdata[KB-1:0];
                REG_ENC_EXP: r_enc_exp <= pwdata[KB-1:0];
                REG_DEC_EXP: r_dec_exp <= pwdata[KB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_MODULUS: prdata = {{(32-KB){1'b0}}, r_modulus};
            REG_ENC_EXP: prdata = {{(32-KB){1'b0}}, r_enc_exp};
            REG_DEC_EXP: prdata = {{(32-KB){1'b0}}, r_dec_exp};
            default:     prdata = '0;
        endcase
    end

    // The pipeline moves as one unless a finished result is being held.
    assign en      = !(stage_valid[N_STAGES] && i_stall);
    assign o_stall = !en;

    assign stage_valid[0]     = i_valid;
    assign stage_lane[0].func = i_func;
    assign stage_lane[0].base = i_value;
    assign stage_lane[0].pw   = '0;
    assign stage_lane[0].mm   = '0;

    // Base reduction, most significant dividend bit first.
    for (genvar k = 0; k < RED_STAGES; k++) begin : g_red
        rme_red_step u_red (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (stage_valid[k]),
            .i_lane  (stage_lane[k]),
            .i_bit   (stage_lane[k].base[KB-1-k]),
            .i_last  (k == RED_STAGES - 1),
            .i_mod   (r_modulus),
            .o_valid (stage_valid[k+1]),
            .o_lane  (stage_lane[k+1])
        );
    end

    // Left-to-right square and multiply. Phase 0 squares, phase 1 multiplies
    // by the base and keeps the product only when the exponent bit is set.
    for (genvar e = 0; e < KB; e++) begin : g_exp
        for (genvar ph = 0; ph < 2; ph++) begin : g_phase
            for (genvar k = 0; k < KB; k++) begin : g_bit
                localparam int S = RED_STAGES + (e * 2 + ph) * KB + k;
                logic  bbit;
                logic  commit;
                t_lane lane_in;

                assign lane_in = stage_lane[S];
                assign bbit    = (ph == 0) ? lane_in.pw[KB-1-k] : lane_in.base[KB-1-k];
                assign commit  = (ph == 0) ? 1'b1
                               : (lane_in.func ? r_dec_exp[KB-1-e] : r_enc_exp[KB-1-e]);

                rme_mm_step u_mm (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_en     (en),
                    .i_valid  (stage_valid[S]),
                    .i_lane   (lane_in),
                    .i_bbit   (bbit),
                    .i_last   (k == KB - 1),
                    .i_commit (commit),
                    .i_mod    (r_modulus),
                    .o_valid  (stage_valid[S+1]),
                    .o_lane   (stage_lane[S+1])
                );
            end
        end
    end

    assign o_valid  = stage_valid[N_STAGES];
    assign o_result = (r_modulus < t_key'(2)) ? '0 : stage_lane[N_STAGES].pw;

    a_stall_only_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a held result");

    a_result_below_modulus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_modulus >= t_key'(2)) |-> (o_result < r_modulus))
        else $error("result not reduced below modulus");

    a_small_modulus_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_modulus < t_key'(2)) |-> (o_result == '0))
        else $error("nonzero result for modulus below two");

endmodule

[rtl/rme_red_step.sv]
module rme_red_step
    import rme_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_lane i_lane,
    input  logic  i_bit,
    input  logic  i_last,
    input  t_key  i_mod,
    output logic  o_valid,
    output t_lane o_lane
);

    logic          r_valid;
    t_lane         r_lane;
    t_lane         n_lane;
    logic [KB:0]   trial;

    // One restoring division step: shift in the next dividend bit and
    // subtract the modulus when it fits.
    always_comb begin
        trial = {i_lane.mm, i_bit};
        if (trial >= {1'b0, i_mod}) begin
            trial = trial - {1'b0, i_mod};
        end
        n_lane    = i_lane;
        n_lane.mm = trial[KB-1:0];
        if (i_last) begin
            n_lane.base = trial[KB-1:0];
            n_lane.pw   = t_key'(1);
            n_lane.mm   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

[rtl/rme_mm_step.sv]
module rme_mm_step
    import rme_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_lane i_lane,
    input  logic  i_bbit,
    input  logic  i_last,
    input  logic  i_commit,
    input  t_key  i_mod,
    output logic  o_valid,
    output t_lane o_lane
);

    logic  r_valid;
    t_lane r_lane;
    t_lane n_lane;
    t_key  dbl;
    t_key  acc;

    // One bit of shift-and-add modular multiplication of pw by b.
    always_comb begin
        dbl = add_mod(i_lane.mm, i_lane.mm, i_mod);
        acc = i_bbit ? add_mod(dbl, i_lane.pw, i_mod) : dbl;
        n_lane    = i_lane;
        n_lane.mm = acc;
        if (i_last) begin
            if (i_commit) begin
                n_lane.pw = acc;
            end
            n_lane.mm = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

[tb/sv/rme_checker.sv]
module rme_checker
    import rme_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  logic          in_func,
    input  logic [KB-1:0] in_value,
    input  logic          out_valid,
    input  logic          out_stall,
    input  logic [KB-1:0] out_result,
    input  logic          cfg_sel,
    input  logic          cfg_enable,
    input  logic          cfg_write,
    input  logic          cfg_ready,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [31:0]   cfg_wdata,
    output int            fail_count,
    output int            pending_count
);

    t_key key_mod;
    t_key key_enc;
    t_key key_dec;
    t_key expected_results[$];

    // Addition modulo m for operands already reduced below m.
    function automatic t_key sum_reduced(t_key a, t_key b, t_key m);
        t_key room;
        room = m - b;
        return (a >= room) ? a - room : a + b;
    endfunction

    function automatic t_key product_reduced(t_key a, t_key b, t_key m);
        t_key acc;
        acc = '0;
        for (int i = KB - 1; i >= 0; i--) begin
            acc = sum_reduced(acc, acc, m);
            if (b[i]) begin
                acc = sum_reduced(acc, a, m);
            end
        end
        return acc;
    endfunction

    function automatic t_key power_residue(t_key base, t_key pw, t_key m);
        t_key acc;
        t_key b;
        if (m < 2) begin
            return '0;
        end
        b = base % m;
        acc = t_key'(1);
        for (int i = KB - 1; i >= 0; i--) begin
            acc = product_reduced(acc, acc, m);
            if (pw[i]) begin
                acc = product_reduced(acc, b, m);
            end
        end
        return acc;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_mod <= t_key'(2);
            key_enc <= t_key'(1);
            key_dec <= t_key'(1);
            fail_count <= 0;
            expected_results.delete();
        end else begin
            if (cfg_sel && cfg_enable && cfg_write && cfg_ready) begin
                case (cfg_addr[ADDR_W-1:2])
                    REG_MODULUS: key_mod <= cfg_wdata[KB-1:0];
                    REG_ENC_EXP: key_enc <= cfg_wdata[KB-1:0];
                    REG_DEC_EXP: key_dec <= cfg_wdata[KB-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                expected_results.push_back(
                    power_residue(in_value, in_func ? key_dec : key_enc, key_mod));
            end
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) begin
                        $display("unexpected result %0d", out_result);
                    end
                end else begin
                    if (expected_results[0] !== out_result) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10) begin
                            $display("result mismatch: expected %0d actual %0d",
                                     expected_results[0], out_result);
                        end
                    end
                    void'(expected_results.pop_front());
                end
            end
        end
    end

endmodule

[tb/sv/rsa_modular_exponentiation_tb.sv]
module rsa_modular_exponentiation_tb;
    import rme_pkg::*;

    // Pipeline depth: the reduction stages plus the multiply stages.
    localparam int LATENCY = RED_STAGES + MM_STAGES;
    // The hold-off phase keeps sending until the receiver lets go, so it
    // carries several hundred more transactions than the other phases.
    localparam int RANDOM_ITEMS = 1150;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_func;
    logic [KB-1:0]     i_value;
    logic              o_valid;
    logic              i_stall;
    logic [KB-1:0]     o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int  fail_count;
    int  pending_count;
    t_key cur_mod;
    // The receiver process holds off for a long stretch while this is set.
    bit  hold_off_request;

    rsa_modular_exponentiation u_dut (.*);

    rme_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_valid(i_valid), .in_stall(o_stall), .in_func(i_func), .in_value(i_value),
        .out_valid(o_valid), .out_stall(i_stall), .out_result(o_result),
        .cfg_sel(psel), .cfg_enable(penable), .cfg_write(pwrite), .cfg_ready(pready),
        .cfg_addr(paddr), .cfg_wdata(pwdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Register write with a setup phase, then an access phase. pready is always high.
    task automatic write_key(t_reg_idx idx, t_key val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= 32'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MODULUS) begin
            cur_mod = val;
        end
    endtask

    // Offer one transaction after a random gap and hold it until accepted.
    // Valid stays high on return so that a following transaction can come
    // back to back; drain_pipeline drops it.
    task automatic send_item(bit func, t_key value);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) begin
            gap = 0;
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Let every expected result drain, then wait out the pipeline depth.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic set_keys(t_key m, t_key e, t_key d);
        write_key(REG_MODULUS, m);
        write_key(REG_ENC_EXP, e);
        write_key(REG_DEC_EXP, d);
    endtask

    function automatic t_key rand_key();
        case ($urandom_range(0, 3))
            0: return t_key'($urandom_range(0, 255));
            1: return {KB{1'b1}};
            default: return t_key'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int wait_cycles;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                i_stall <= 1'b1;
                repeat (LATENCY + 200) @(negedge i_clk);
                hold_off_request = 1'b0;
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 9) < 3) begin
                wait_cycles = $urandom_range(0, 6);
                if (wait_cycles != 0) begin
                    i_stall <= 1'b1;
                    repeat (wait_cycles) @(negedge i_clk);
                end
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_key m;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = 1'b0;
        i_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_off_request = 1'b0;
        cur_mod = t_key'(2);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: reset keys, then extreme moduli and exponents.
        send_item(1'b0, '0);
        send_item(1'b1, {KB{1'b1}});
        drain_pipeline();
        // A modulus of one yields zero everywhere, and so does zero.
        set_keys(t_key'(1), t_key'(0), {KB{1'b1}});
        send_item(1'b0, t_key'(5));
        send_item(1'b1, {KB{1'b1}});
        drain_pipeline();
        set_keys(t_key'(0), t_key'(3), t_key'(7));
        send_item(1'b0, t_key'(9));
        send_item(1'b1, t_key'(1));
        drain_pipeline();
        // Largest modulus; exponent zero gives one; bases at and below the modulus.
        set_keys({KB{1'b1}}, t_key'(0), {KB{1'b1}});
        send_item(1'b0, t_key'(12345));
        send_item(1'b1, {KB{1'b1}});
        send_item(1'b1, t_key'({KB{1'b1}} - 1));
        send_item(1'b1, t_key'(0));
        send_item(1'b0, t_key'(0));
        drain_pipeline();
        // Small textbook key with an even modulus as well.
        set_keys(t_key'(3233), t_key'(17), t_key'(2753));
        send_item(1'b0, t_key'(65));
        send_item(1'b1, t_key'(2790));
        send_item(1'b0, t_key'(3233));
        send_item(1'b1, t_key'(5000));
        drain_pipeline();
        set_keys(t_key'(100), t_key'(1), t_key'(2));
        send_item(1'b0, t_key'(150));
        send_item(1'b1, t_key'(99));
        drain_pipeline();

        // Random part: phases with fresh keys, one phase with a long hold-off
        // during which the sender keeps offering until the receiver lets go.
        for (int phase = 0; phase < 7; phase++) begin
            m = rand_key();
            if ($urandom_range(0, 5) == 0) begin
                m = t_key'($urandom_range(0, 3));
            end
            set_keys(m, rand_key(), rand_key());
            if (phase == 3) begin
                hold_off_request = 1'b1;
            end
            for (int k = 0; k < RANDOM_ITEMS / 7 || (phase == 3 && hold_off_request);
                 k++) begin
                if ($urandom_range(0, 4) == 0 || cur_mod == 0) begin
                    send_item(1'($urandom_range(0, 1)), t_key'($urandom));
                end else begin
                    send_item(1'($urandom_range(0, 1)),
                              t_key'($urandom_range(0, cur_mod - 1)));
                end
            end
            drain_pipeline();
        end

        if (fail_count == 0) begin
            $display("[rsa_modular_exponentiation] OK");
        end else begin
            $display("[rsa_modular_exponentiation] ERROR");
        end
        $finish;
    end

    // Safety limit, far above the slowest correct run.
    initial begin
        #(64'd10 * 64'd4000000);
        $display("[rsa_modular_exponentiation] ERROR");
        $finish;
    end

endmodule
